// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SIT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SIT_ASSERT(lbl, prop, msg)
`define SIT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- sv/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the sorted interpolation table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int DEPTH = 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DEFAULT = 3'd1;
    localparam logic [2:0] ST_ORDER   = 3'd2;
    localparam logic [2:0] ST_START   = 3'd3;
    localparam logic [2:0] ST_TO_END  = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    localparam logic CFG_DEFAULT = 1'b0;
    localparam logic CFG_STEP    = 1'b1;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [DW-1:0] arg;
        logic signed [DW-1:0] val;
        logic [CW-1:0]        first_index;
        logic [CW-1:0]        end_index;
    } t_req;

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic [2:0]           status;
        logic [CW-1:0]        count;
    } t_rsp;

endpackage

// ----- sv/sorted_interpolation_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_interpolation_table_top
// Sorted table of Q16.16 points with insert, interpolated lookup and erase.
// ----------------------------------------------------------------------------
// One request at a time: accepted when start is high and busy low; the
// response appears on o_rsp for one cycle with o_done and cannot be stalled.
// All points live in one 256-entry RAM.
// Insert scans from index 0 for the first point not below the argument,
// raising a duplicate by the step as part of the scan, then shifts later
// points up one at a time and writes the new one; an append needs no shift.
// Lookup scans to the first point above the argument, reads the points on
// both sides and, if the interval has width, multiplies and divides; out of
// range gives the default. Erase moves points from end_index down to
// first_index; status-only answers skip the RAM. Config writes are always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_interpolation_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sit_pkg::t_req i_req,
    output logic          o_done,
    output sit_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import sit_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_INS_RD  = 5'd2;
    localparam logic [4:0] S_INS_CMP = 5'd3;
    localparam logic [4:0] S_SHF_RD  = 5'd4;
    localparam logic [4:0] S_SHF_WR  = 5'd5;
    localparam logic [4:0] S_INS_WR  = 5'd6;
    localparam logic [4:0] S_LK_RD   = 5'd7;
    localparam logic [4:0] S_LK_CMP  = 5'd8;
    localparam logic [4:0] S_LK_SEL  = 5'd9;
    localparam logic [4:0] S_LK_LO   = 5'd10;
    localparam logic [4:0] S_LK_UP   = 5'd11;
    localparam logic [4:0] S_LK_CAP  = 5'd12;
    localparam logic [4:0] S_LK_PREP = 5'd13;
    localparam logic [4:0] S_LK_MUL  = 5'd14;
    localparam logic [4:0] S_LK_GO   = 5'd15;
    localparam logic [4:0] S_LK_DIV  = 5'd16;
    localparam logic [4:0] S_ERS_RD  = 5'd17;
    localparam logic [4:0] S_ERS_WR  = 5'd18;

    logic [4:0]    r_state, n_state;
    t_req          r_req, n_req;
    logic [DW-1:0] r_a, n_a;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_sh, n_sh;
    logic [CW-1:0] r_count, n_count;
    logic          r_eq, n_eq;
    logic [AW-1:0] r_lo, n_lo;
    logic [AW-1:0] r_up, n_up;
    logic [DW-1:0] r_alo, n_alo, r_vlo, n_vlo, r_aup, n_aup, r_vup, n_vup;
    logic [DW-1:0] r_dvs, n_dvs, r_t, n_t, r_mag, n_mag;
    logic          r_neg, n_neg;
    logic [63:0]   r_prod, n_prod;
    logic [DW-1:0] r_dflt;
    logic [30:0]   r_step;
    logic          r_done, n_done;
    t_rsp          r_rsp, n_rsp;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0]   mem_wdata, mem_q;
    logic [DW-1:0] q_arg;
    logic          div_start, div_done;
    logic [31:0]   div_q;

    logic [32:0]   raised;
    logic [CW-1:0] sh_m1, up_w, lo_w;
    logic [32:0]   diff33, t33, dv33, mag33, sum33, avg33;

    assign q_arg = mem_q[63:32];

    sit_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    sit_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_a     = r_a;
        n_idx   = r_idx;
        n_sh    = r_sh;
        n_count = r_count;
        n_eq    = r_eq;
        n_lo    = r_lo;
        n_up    = r_up;
        n_alo   = r_alo;
        n_vlo   = r_vlo;
        n_aup   = r_aup;
        n_vup   = r_vup;
        n_dvs   = r_dvs;
        n_t     = r_t;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_prod  = r_prod;
        n_done  = 1'b0;
        n_rsp   = r_rsp;

        mem_we    = 1'b0;
        mem_waddr = r_sh[AW-1:0];
        mem_wdata = mem_q;
        mem_raddr = r_idx[AW-1:0];
        div_start = 1'b0;

        raised = {r_a[DW-1], r_a} + {2'b00, r_step};
        sh_m1  = r_sh - CW'(1);
        up_w   = (r_idx == r_count) ? r_count - CW'(1) : r_idx;
        lo_w   = (up_w == '0) ? '0 : up_w - CW'(1);
        diff33 = {r_aup[DW-1], r_aup} - {r_alo[DW-1], r_alo};
        t33    = {r_a[DW-1], r_a} - {r_alo[DW-1], r_alo};
        dv33   = {r_vup[DW-1], r_vup} - {r_vlo[DW-1], r_vlo};
        mag33  = dv33[32] ? -dv33 : dv33;
        sum33  = {r_vlo[DW-1], r_vlo} + {r_vup[DW-1], r_vup};
        avg33  = sum33 + {32'd0, sum33[32] & sum33[0]};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_a     = i_req.arg;
                    n_idx   = '0;
                    n_eq    = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_req.kind)
                    KIND_INSERT: begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_done = 1'b1; n_rsp.value = '0; n_rsp.status = ST_FULL;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (r_count == '0) begin
                            n_done = 1'b1; n_rsp.value = r_dflt; n_rsp.status = ST_DEFAULT;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_LK_RD;
                        end
                    end
                    KIND_ERASE: begin
                        n_done = 1'b1; n_rsp.value = '0; n_state = S_IDLE;
                        if (r_req.first_index >= r_req.end_index) begin
                            n_rsp.status = ST_ORDER;
                        end else if (r_req.first_index >= r_count) begin
                            n_rsp.status = ST_START;
                        end else if (r_req.end_index > r_count) begin
                            n_count      = r_req.first_index;
                            n_rsp.status = ST_TO_END;
                        end else begin
                            n_done  = 1'b0;
                            n_idx   = r_req.end_index;
                            n_sh    = r_req.first_index;
                            n_state = S_ERS_RD;
                        end
                    end
                    default: begin
                        n_done = 1'b1; n_rsp.value = '0; n_rsp.status = ST_OK;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INS_RD: begin
                n_state = (r_idx == r_count) ? S_INS_WR : S_INS_CMP;
            end
            S_INS_CMP: begin
                if ($signed(q_arg) < $signed(r_a)) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_INS_RD;
                end else if (q_arg == r_a && r_step != '0) begin
                    if (raised[32:31] == 2'b01) begin
                        n_done = 1'b1; n_rsp.value = '0; n_rsp.status = ST_FULL;
                        n_state = S_IDLE;
                    end else begin
                        n_a     = raised[31:0];
                        n_idx   = r_idx + CW'(1);
                        n_state = S_INS_RD;
                    end
                end else begin
                    n_sh    = r_count;
                    n_state = S_SHF_RD;
                end
            end
            S_SHF_RD: begin
                mem_raddr = sh_m1[AW-1:0];
                n_state   = (r_sh == r_idx) ? S_INS_WR : S_SHF_WR;
            end
            S_SHF_WR: begin
                mem_we  = 1'b1;
                n_sh    = sh_m1;
                n_state = S_SHF_RD;
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = {r_a, r_req.val};
                n_count   = r_count + CW'(1);
                n_done = 1'b1; n_rsp.value = '0; n_rsp.status = ST_OK;
                n_state = S_IDLE;
            end
            S_LK_RD: begin
                n_state = (r_idx == r_count) ? S_LK_SEL : S_LK_CMP;
            end
            S_LK_CMP: begin
                n_eq = (q_arg == r_a);
                if ($signed(q_arg) <= $signed(r_a)) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_LK_RD;
                end else begin
                    n_state = S_LK_SEL;
                end
            end
            S_LK_SEL: begin
                if (r_idx == '0 || (r_idx == r_count && !r_eq)) begin
                    n_done = 1'b1; n_rsp.value = r_dflt; n_rsp.status = ST_DEFAULT;
                    n_state = S_IDLE;
                end else begin
                    n_up    = up_w[AW-1:0];
                    n_lo    = lo_w[AW-1:0];
                    n_state = S_LK_LO;
                end
            end
            S_LK_LO: begin
                mem_raddr = r_lo;
                n_state   = S_LK_UP;
            end
            S_LK_UP: begin
                n_alo     = mem_q[63:32];
                n_vlo     = mem_q[31:0];
                mem_raddr = r_up;
                n_state   = S_LK_CAP;
            end
            S_LK_CAP: begin
                n_aup   = mem_q[63:32];
                n_vup   = mem_q[31:0];
                n_state = S_LK_PREP;
            end
            S_LK_PREP: begin
                if (diff33 == '0) begin
                    n_done = 1'b1; n_rsp.value = avg33[32:1]; n_rsp.status = ST_OK;
                    n_state = S_IDLE;
                end else begin
                    n_dvs   = diff33[31:0];
                    n_t     = t33[31:0];
                    n_mag   = mag33[31:0];
                    n_neg   = dv33[32];
                    n_state = S_LK_MUL;
                end
            end
            S_LK_MUL: begin
                n_prod  = r_mag * r_t;
                n_state = S_LK_GO;
            end
            S_LK_GO: begin
                div_start = 1'b1;
                n_state   = S_LK_DIV;
            end
            S_LK_DIV: begin
                if (div_done) begin
                    n_done = 1'b1;
                    n_rsp.value  = r_neg ? r_vlo - div_q : r_vlo + div_q;
                    n_rsp.status = ST_OK;
                    n_state = S_IDLE;
                end
            end
            S_ERS_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_sh;
                    n_done = 1'b1; n_rsp.value = '0; n_rsp.status = ST_OK;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ERS_WR;
                end
            end
            S_ERS_WR: begin
                mem_we  = 1'b1;
                n_idx   = r_idx + CW'(1);
                n_sh    = r_sh + CW'(1);
                n_state = S_ERS_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_dflt  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DEFAULT: r_dflt <= i_cfg_data;
                    CFG_STEP:    r_step <= i_cfg_data[30:0];
                    default:     r_dflt <= r_dflt;
                endcase
            end
        end
        r_req  <= n_req;
        r_a    <= n_a;
        r_idx  <= n_idx;
        r_sh   <= n_sh;
        r_eq   <= n_eq;
        r_lo   <= n_lo;
        r_up   <= n_up;
        r_alo  <= n_alo;
        r_vlo  <= n_vlo;
        r_aup  <= n_aup;
        r_vup  <= n_vup;
        r_dvs  <= n_dvs;
        r_t    <= n_t;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_rsp  <= n_rsp;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

    `SIT_ASSERT(a_done_pulse, o_done |=> !o_done, "response strobe longer than one cycle")
    `SIT_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted request did not raise busy")
    `SIT_ASSERT(a_done_idle, o_done |-> !busy && o_rsp.count == r_count, "response out of step")
    `SIT_ASSERT(a_count_max, r_count <= CW'(DEPTH), "point count beyond table depth")
endmodule

// ----- sv/sit_ram.sv -----
// ----------------------------------------------------------------------------
// sit_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- sv/sit_div.sv -----
// ----------------------------------------------------------------------------
// sit_div
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Needs dividend[63:32] below divisor; quotient fits 32 bits.
// ----------------------------------------------------------------------------
module sit_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import sit_pkg::*;

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs, n_dvs;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_run, n_run;
    logic        r_done, n_done;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[31]};
        diff   = trial - {1'b0, r_dvs};
        if (i_start) begin
            n_rem = i_dividend[63:32];
            n_quo = i_dividend[31:0];
            n_dvs = i_divisor;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (!diff[32]) begin
                n_rem = diff[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = trial[31:0];
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ----- tb/sv/tb_sorted_interpolation_table_top.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_interpolation_table_top
// Drives insert, lookup and erase requests into the sorted interpolation
// table, predicts each response with a behavioural table of its own, and
// compares value, status and count of every response against it.
// ----------------------------------------------------------------------------
module tb_sorted_interpolation_table_top;
    import sit_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    sorted_interpolation_table_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    localparam int WATCHDOG = 20000;

    // model table
    longint tbl_arg [DEPTH];
    longint tbl_val [DEPTH];
    int     tbl_n;
    longint dflt_val;
    longint dup_step;

    t_rsp   rsp_queue [$];
    int     errors;
    int     n_reqs;
    int     n_rsps;
    int     idle_cycles;
    bit     gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void table_put(int pos, longint a, longint v);
        for (int i = tbl_n; i > pos; i--) begin
            tbl_arg[i] = tbl_arg[i-1];
            tbl_val[i] = tbl_val[i-1];
        end
        tbl_arg[pos] = a;
        tbl_val[pos] = v;
        tbl_n++;
    endfunction

    function automatic logic [2:0] table_insert(longint a0, longint v);
        longint a;
        int     pos;
        a = a0;
        if (tbl_n >= DEPTH) return ST_FULL;
        for (int g = 0; g <= DEPTH; g++) begin
            if (tbl_n == 0 || a > tbl_arg[tbl_n-1]) begin
                table_put(tbl_n, a, v);
                return ST_OK;
            end
            pos = 0;
            while (pos < tbl_n && tbl_arg[pos] < a) pos++;
            if (pos < tbl_n && tbl_arg[pos] == a && dup_step != 0) begin
                a += dup_step;
                if (a > 64'sd2147483647) return ST_FULL;
                continue;
            end
            table_put(pos, a, v);
            return ST_OK;
        end
        return ST_FULL;
    endfunction

    function automatic logic [2:0] table_interp(longint a, output longint res);
        int     ins, up, lo;
        longint alo, aup, vlo, vup, dv, mag, q;
        if (tbl_n == 0 || a < tbl_arg[0] || a > tbl_arg[tbl_n-1]) begin
            res = dflt_val;
            return ST_DEFAULT;
        end
        ins = 0;
        while (ins < tbl_n && tbl_arg[ins] <= a) ins++;
        up = (ins == tbl_n) ? ins - 1 : ins;
        lo = (up != 0) ? up - 1 : up;
        alo = tbl_arg[lo]; aup = tbl_arg[up];
        vlo = tbl_val[lo]; vup = tbl_val[up];
        if (aup - alo > 0) begin
            dv  = vup - vlo;
            mag = dv < 0 ? -dv : dv;
            // product fits in 64 bits unsigned; operands are below 2^32
            q = longint'((unsigned'(mag) * unsigned'(a - alo)) / unsigned'(aup - alo));
            res = dv < 0 ? vlo - q : vlo + q;
        end else begin
            res = (vlo + vup) / 2;
        end
        return ST_OK;
    endfunction

    function automatic logic [2:0] table_erase(int first, int last);
        if (first >= last) return ST_ORDER;
        if (first >= tbl_n) return ST_START;
        if (last > tbl_n) begin
            tbl_n = first;
            return ST_TO_END;
        end
        for (int s = last, d = first; s < tbl_n; s++, d++) begin
            tbl_arg[d] = tbl_arg[s];
            tbl_val[d] = tbl_val[s];
        end
        tbl_n -= last - first;
        return ST_OK;
    endfunction

    function automatic t_rsp predict_table(t_req r);
        t_rsp   p;
        longint res;
        res = 0;
        p.status = ST_OK;
        case (r.kind)
            KIND_INSERT: p.status = table_insert(longint'(r.arg), longint'(r.val));
            KIND_LOOKUP: p.status = table_interp(longint'(r.arg), res);
            KIND_ERASE:  p.status = table_erase(int'(r.first_index), int'(r.end_index));
            default: ;
        endcase
        p.value = res[31:0];
        p.count = tbl_n[CW-1:0];
        return p;
    endfunction

    // response checker and watchdog
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n) begin
            if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("** sorted_interpolation_table_top: FAILED **");
                $finish;
            end
            if (o_done) begin
                n_rsps++;
                if (rsp_queue.size() == 0) begin
                    errors++;
                    $error("unexpected response %p", o_rsp);
                end else begin
                    exp_rsp = rsp_queue.pop_front();
                    if (o_rsp.value !== exp_rsp.value) begin
                        errors++;
                        $error("value: expected %0d, got %0d", exp_rsp.value, o_rsp.value);
                    end
                    if (o_rsp.status !== exp_rsp.status) begin
                        errors++;
                        $error("status: expected %0d, got %0d", exp_rsp.status,
                               o_rsp.status);
                    end
                    if (o_rsp.count !== exp_rsp.count) begin
                        errors++;
                        $error("count: expected %0d, got %0d", exp_rsp.count, o_rsp.count);
                    end
                end
            end
        end
    end

    task automatic random_gap();
        if (gaps_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
    endtask

    task automatic send_request(t_req r);
        random_gap();
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        rsp_queue = {rsp_queue, predict_table(r)};
        n_reqs++;
        start <= 1'b0;
        // the block stays busy for at least this cycle
        @(posedge i_clk);
    endtask

    task automatic drain_responses();
        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        drain_responses();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DEFAULT) dflt_val = longint'(signed'(data));
        else dup_step = longint'(data[30:0]);
    endtask

    function automatic t_req make_req(logic [1:0] k, logic [31:0] a, logic [31:0] v,
                                      int f, int e);
        t_req r;
        r.kind = k; r.arg = a; r.val = v;
        r.first_index = f[CW-1:0]; r.end_index = e[CW-1:0];
        return r;
    endfunction

    task automatic do_insert(logic [31:0] a, logic [31:0] v);
        send_request(make_req(KIND_INSERT, a, v, $urandom_range(0, 511),
                              $urandom_range(0, 511)));
    endtask

    task automatic do_lookup(logic [31:0] a);
        send_request(make_req(KIND_LOOKUP, a, $urandom, $urandom_range(0, 511),
                              $urandom_range(0, 511)));
    endtask

    task automatic do_erase(int f, int e);
        send_request(make_req(KIND_ERASE, $urandom, $urandom, f, e));
    endtask

    task automatic clear_table();
        do_erase(0, 256);
    endtask

    task automatic test_directed();
        do_lookup(32'h0);
        write_reg(CFG_DEFAULT, 32'h8000_0000);
        do_lookup(32'h7fff_ffff);
        do_insert(32'h0001_0000, 32'h7fff_ffff);
        do_lookup(32'h0001_0000);
        do_insert(32'h0001_0000, 32'h8000_0000);
        do_lookup(32'h0001_0000);
        do_insert(32'h8000_0000, 32'h8000_0000);
        do_insert(32'h7fff_ffff, 32'h7fff_ffff);
        do_lookup(32'h0000_8000);
        do_lookup(32'h4000_0000);
        do_lookup(32'hc000_0001);
        send_request(make_req(KIND_NONE, $urandom, $urandom, 5, 1));
        do_erase(3, 3);
        do_erase(5, 2);
        do_erase(7, 9);
        do_erase(1, 300);
        write_reg(CFG_STEP, 32'h7fff_ffff);
        do_insert(32'h0000_0000, 32'h0000_1000);
        do_insert(32'h8000_0000, 32'h0000_2000);
        do_insert(32'h8000_0000, 32'h0000_3000);
        write_reg(CFG_STEP, 32'h0000_8000);
        do_insert(32'h8000_0000, 32'h0000_4000);
        do_lookup(32'h8000_4000);
        do_erase(0, 2);
        clear_table();
    endtask

    task automatic test_fill_full();
        write_reg(CFG_STEP, 32'h0000_0000);
        for (int i = 0; i < DEPTH + 2; i++)
            do_insert($urandom_range(0, 31) << 16, $urandom);
        do_lookup(32'h0004_0000);
        do_erase(DEPTH - 1, DEPTH);
        do_erase(0, DEPTH);
        do_erase(0, 1);
    endtask

    task automatic test_random(int n_items);
        int          k;
        logic [31:0] a;
        for (int i = 0; i < n_items; i++) begin
            if (i % 300 == 150) begin
                drain_responses();
                write_reg(CFG_DEFAULT, $urandom);
                write_reg(CFG_STEP, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8) << 14);
            end
            k = $urandom_range(0, 99);
            a = ($urandom_range(0, 3) == 0) ? $urandom
                                            : 32'(signed'($urandom_range(0, 64) - 32)) << 14;
            if (k < 45 && tbl_n < 48)
                do_insert(a, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255) << 12);
            else if (k < 85)
                do_lookup(a);
            else if (k < 97)
                do_erase($urandom_range(0, tbl_n + 2), $urandom_range(0, tbl_n + 4));
            else if (k < 99)
                do_erase($urandom_range(0, 511), $urandom_range(0, 511));
            else
                send_request(make_req(KIND_NONE, $urandom, $urandom, $urandom_range(0, 511),
                                      $urandom_range(0, 511)));
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_DEFAULT;
        i_cfg_data  <= '0;
        tbl_n = 0; dflt_val = 0; dup_step = 0;
        errors = 0; n_reqs = 0; n_rsps = 0; idle_cycles = 0; gaps_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_full();
        test_random(1000);
        gaps_on = 1'b0;
        test_random(150);
        drain_responses();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d requests (insert, lookup, erase, unused kind), %0d responses",
                 n_reqs, n_rsps);
        $display("Covered full table, duplicate raises, defaults and all erase statuses");
        if (errors == 0 && rsp_queue.size() == 0) begin
            $display("** sorted_interpolation_table_top: PASSED **");
        end else begin
            $display("** sorted_interpolation_table_top: FAILED **");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/sit_pkg.sv
sv/sit_ram.sv
sv/sit_div.sv
sv/sorted_interpolation_table_top.sv
tb/sv/tb_sorted_interpolation_table_top.sv
